// ----- src/mctg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock/transport package
// Shared widths, codes and the control/status bundles between the controller
// and the datapath of the transport generator.
// ----------------------------------------------------------------------------
package mctg_pkg;

	// Field and register widths.
	localparam int OP_W       = 2;
	localparam int TICK_W     = 31;
	localparam int LAST_W     = 32;
	localparam int MODE_W     = 2;
	localparam int PPQ_W      = 12;
	localparam int MODU_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int DIVR_W     = 21;
	localparam int STAT_W     = 8;
	localparam int DATA_W     = 7;

	// Default per-item limit on emitted clocks.
	localparam int MAX_CLOCKS_DEF = 64;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPQ     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd2;

	// Reset values of the registers.
	localparam logic [MODE_W-1:0] MODE_RST = 2'd0;
	localparam logic [PPQ_W-1:0]  PPQ_RST  = 12'd192;
	localparam logic [MODU_W-1:0] MODU_RST = 11'd64;

	// Clock modes.
	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALIGN = 2'd2;

	// Operations.
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
	localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
	localparam logic [OP_W-1:0] OP_ADV   = 2'd3;

	// Smallest usable pulses per quarter, and reciprocal of three in Q9.
	localparam int PPQ_MIN    = 24;
	localparam int RECIP3     = 171;
	localparam int RECIP3_SH  = 9;

	// MIDI status bytes.
	localparam logic [STAT_W-1:0] ST_START = 8'hFA;
	localparam logic [STAT_W-1:0] ST_STOP  = 8'hFC;
	localparam logic [STAT_W-1:0] ST_CONT  = 8'hFB;
	localparam logic [STAT_W-1:0] ST_SPP   = 8'hF2;
	localparam logic [STAT_W-1:0] ST_CLOCK = 8'hF8;

	// Kind of word to emit.
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_START = 3'd0;
	localparam kind_t KIND_STOP  = 3'd1;
	localparam kind_t KIND_CONT  = 3'd2;
	localparam kind_t KIND_SPP   = 3'd3;
	localparam kind_t KIND_CLK   = 3'd4;

	// Divider operand selection.
	typedef logic [1:0] div_src_t;
	localparam div_src_t DSRC_P16      = 2'd0;
	localparam div_src_t DSRC_SPAN     = 2'd1;
	localparam div_src_t DSRC_PER_TICK = 2'd2;
	localparam div_src_t DSRC_PER_LAST = 2'd3;

	typedef struct packed {
		logic     latch_in;
		logic     div_start;
		div_src_t div_src;
		logic     save_qt;
		logic     last_neg;
		logic     last_round;
		logic     last_tick;
		logic     calc;
		logic     out_load;
		kind_t    out_kind;
		logic     out_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            on;
		logic            mode_spp;
		logic            mode_align;
		logic            tick_zero;
		logic            adv_fwd;
		logic            last_neg;
		logic            div_done;
		logic            out_free;
	} dp_status_t;

	function automatic logic [STAT_W-1:0] kind_status(input kind_t k);
		logic [STAT_W-1:0] s;
		case (k)
			KIND_START: s = ST_START;
			KIND_STOP:  s = ST_STOP;
			KIND_CONT:  s = ST_CONT;
			KIND_SPP:   s = ST_SPP;
			KIND_CLK:   s = ST_CLOCK;
			default:    s = ST_CLOCK;
		endcase
		return s;
	endfunction

endpackage

// ----- src/mctg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock/transport channels
// Valid/ready channels for transport commands and emitted MIDI words.
// ----------------------------------------------------------------------------
interface mctg_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [mctg_pkg::OP_W-1:0]     operation;
	logic [mctg_pkg::TICK_W-1:0]   target_tick;

	modport source (output valid, output operation, output target_tick, input ready);
	modport sink   (input valid, input operation, input target_tick, output ready);
endinterface

interface mctg_msg_if;
	logic                          valid;
	logic                          ready;
	logic [mctg_pkg::STAT_W-1:0]   status_byte;
	logic [mctg_pkg::DATA_W-1:0]   data_one;
	logic [mctg_pkg::DATA_W-1:0]   data_two;
	logic                          last_of_run;
	logic                          clocks_dropped;

	modport source (output valid, output status_byte, output data_one, output data_two,
		output last_of_run, output clocks_dropped, input ready);
	modport sink   (input valid, input status_byte, input data_one, input data_two,
		input last_of_run, input clocks_dropped, output ready);
endinterface

// ----- src/midi_clock_transport_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock and transport generator
// Turns transport commands into MIDI start, stop, continue, song position
// and timing clock words.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel (operation, target_tick) and the MIDI
// words they cause leave on the msg channel, one word per handshake; the
// last word of each command carries last_of_run. Registers clock_mode,
// pulses_per_quarter and start_modulus are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while no command
// is in flight, as the block itself does not enforce this.
// One command at a time. Start and stop pass through decode and the emit
// state, which places their word in the output register. The bit-serial
// divider yields 31 quotient bits, then raises its done flag. Init at tick
// divides the tick by a sixteenth or by the alignment span before its first
// word. Advance to tick divides once, or twice when a tick has already been
// clocked, before its first clock word; the rest follow one per cycle while
// the receiver takes them, at most MAX_CLOCKS.
// The next command is accepted once the last word has been placed in the
// output register, even while that word waits to be taken.
// Reset clears the registers to their defaults, sets the last clocked tick
// to minus one and empties the output register. A stalled receiver holds
// the current word and pauses emission of the rest of the run.
// ----------------------------------------------------------------------------
module midi_clock_transport_generator_top #(
	parameter int MAX_CLOCKS = mctg_pkg::MAX_CLOCKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mctg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mctg_pkg::CFG_DATA_W-1:0]   cfg_data,
	mctg_cmd_if.sink                          cmd,
	mctg_msg_if.source                        msg
);
	import mctg_pkg::*;

	ctrl_cmd_t                      ctl;
	dp_status_t                     dp_status;
	logic [$clog2(MAX_CLOCKS+1)-1:0] due_cnt;

	// The controller owns sequencing; it sees only the datapath's status and clock count.
	mctg_ctrl #(
		.MAX_CLOCKS (MAX_CLOCKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.status   (dp_status),
		.due_cnt  (due_cnt),
		.cmd      (ctl)
	);

	// The datapath holds the registers, the divider and the output word.
	mctg_dpath #(
		.MAX_CLOCKS (MAX_CLOCKS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_operation   (cmd.operation),
		.in_target_tick (cmd.target_tick),
		.cmd            (ctl),
		.status         (dp_status),
		.due_cnt        (due_cnt),
		.msg            (msg)
	);

endmodule

// ----- src/mctg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock/transport divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mctg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mctg_pkg::TICK_W-1:0]   dividend,
	input  logic [mctg_pkg::DIVR_W-1:0]   divisor,
	output logic [mctg_pkg::TICK_W-1:0]   quotient,
	output logic [mctg_pkg::DIVR_W-1:0]   remainder,
	output logic [mctg_pkg::DIVR_W-1:0]   divisor_used,
	output logic                          done
);
	import mctg_pkg::*;

	localparam int CNT_W = $clog2(TICK_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TICK_W-1:0] quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[TICK_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TICK_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TICK_W-2:0], fits};
			rem_q <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign quotient     = quo_q;
	assign remainder    = rem_q;
	assign divisor_used = dvs_q;
	assign done         = done_q;

endmodule

// ----- src/mctg_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock/transport datapath
// Configuration registers, last clocked tick, divider operands, clock count
// and the output word register.
// ----------------------------------------------------------------------------
module mctg_dpath #(
	parameter int MAX_CLOCKS = mctg_pkg::MAX_CLOCKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mctg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mctg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [mctg_pkg::OP_W-1:0]         in_operation,
	input  logic [mctg_pkg::TICK_W-1:0]       in_target_tick,
	input  mctg_pkg::ctrl_cmd_t               cmd,
	output mctg_pkg::dp_status_t              status,
	output logic [$clog2(MAX_CLOCKS+1)-1:0]   due_cnt,
	mctg_msg_if.source                        msg
);
	import mctg_pkg::*;

	localparam int CNT_W = $clog2(MAX_CLOCKS + 1);

	logic [MODE_W-1:0]        mode_q;
	logic [PPQ_W-1:0]         ppq_q;
	logic [MODU_W-1:0]        modu_q;
	logic [OP_W-1:0]          op_q;
	logic [TICK_W-1:0]        tick_q;
	logic signed [LAST_W-1:0] last_q;
	logic [TICK_W-1:0]        qt_q;
	logic                     drop_q;

	logic [PPQ_W-1:0]         eff;
	logic [PPQ_W-3:0]         p16;
	logic [PPQ_W-4:0]         eighth;
	logic [PPQ_W+5:0]         per_prod;
	logic [7:0]               per;
	logic [MODU_W-1:0]        mod_eff;
	logic [DIVR_W-1:0]        span;
	logic [TICK_W-1:0]        dividend;
	logic [DIVR_W-1:0]        divisor;
	logic [TICK_W-1:0]        quo;
	logic [DIVR_W-1:0]        rem;
	logic [DIVR_W-1:0]        dvs;
	logic                     div_done;
	logic [LAST_W+1:0]        rnd;
	logic [LAST_W-1:0]        rnd_sat;
	logic [LAST_W-1:0]        due;
	logic                     drop;
	logic                     on;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			ppq_q  <= PPQ_RST;
			modu_q <= MODU_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:    mode_q <= cfg_data[MODE_W-1:0];
				REG_PPQ:     ppq_q  <= cfg_data[PPQ_W-1:0];
				REG_MODULUS: modu_q <= cfg_data[MODU_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= in_operation;
			tick_q <= in_target_tick;
		end
		if (cmd.save_qt) begin
			qt_q <= quo;
		end
		if (cmd.calc) begin
			drop_q <= drop;
		end
	end

	// Derived timing constants. The divide by 24 is a shift by three and a
	// multiply by the reciprocal of three, exact over the nine-bit range.
	assign eff      = (ppq_q < PPQ_W'(PPQ_MIN)) ? PPQ_W'(PPQ_MIN) : ppq_q;
	assign p16      = eff[PPQ_W-1:2];
	assign eighth   = eff[PPQ_W-1:3];
	assign per_prod = {9'd0, eighth} * (PPQ_W+6)'(RECIP3);
	assign per      = per_prod[RECIP3_SH+7:RECIP3_SH];
	assign mod_eff  = (modu_q == '0) ? MODU_W'(1) : modu_q;
	assign span     = {{(DIVR_W-PPQ_W+2){1'b0}}, p16} * {{(DIVR_W-MODU_W){1'b0}}, mod_eff};

	always_comb begin
		dividend = tick_q;
		case (cmd.div_src)
			DSRC_P16:      divisor = {{(DIVR_W-PPQ_W+2){1'b0}}, p16};
			DSRC_SPAN:     divisor = span;
			DSRC_PER_TICK: divisor = {{(DIVR_W-8){1'b0}}, per};
			DSRC_PER_LAST: begin
				divisor  = {{(DIVR_W-8){1'b0}}, per};
				dividend = last_q[TICK_W-1:0];
			end
			default:       divisor = {{(DIVR_W-8){1'b0}}, per};
		endcase
	end

	mctg_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (cmd.div_start),
		.dividend     (dividend),
		.divisor      (divisor),
		.quotient     (quo),
		.remainder    (rem),
		.divisor_used (dvs),
		.done         (div_done)
	);

	// Round the tick up to the divisor boundary, minus one, saturated.
	always_comb begin
		if (rem == '0) begin
			rnd = {3'b000, tick_q} - (LAST_W+2)'(1);
		end else begin
			rnd = {3'b000, tick_q} + {{(LAST_W+2-DIVR_W){1'b0}}, dvs}
				- {{(LAST_W+2-DIVR_W){1'b0}}, rem} - (LAST_W+2)'(1);
		end
		if (!rnd[LAST_W+1] && (rnd[LAST_W:TICK_W] != '0)) begin
			rnd_sat = {1'b0, {TICK_W{1'b1}}};
		end else begin
			rnd_sat = rnd[LAST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '1;
		end else if (cmd.last_neg) begin
			last_q <= '1;
		end else if (cmd.last_round) begin
			last_q <= rnd_sat;
		end else if (cmd.last_tick) begin
			last_q <= {1'b0, tick_q};
		end
	end

	// Clocks due: multiples of the clock period up to the target, minus
	// those up to the last clocked tick.
	assign due     = last_q[LAST_W-1] ? ({1'b0, qt_q} + LAST_W'(1))
		: ({1'b0, qt_q} - {1'b0, quo});
	assign drop    = due > LAST_W'(MAX_CLOCKS);
	assign due_cnt = drop ? CNT_W'(MAX_CLOCKS) : due[CNT_W-1:0];

	assign on = (mode_q == MODE_SPP) || (mode_q == MODE_ALIGN);

	assign status.op         = op_q;
	assign status.on         = on;
	assign status.mode_spp   = mode_q == MODE_SPP;
	assign status.mode_align = mode_q == MODE_ALIGN;
	assign status.tick_zero  = tick_q == '0;
	assign status.adv_fwd    = last_q < $signed({1'b0, tick_q});
	assign status.last_neg   = last_q[LAST_W-1];
	assign status.div_done   = div_done;
	assign status.out_free   = !msg.valid || msg.ready;

	// Output word register.
	logic              out_valid_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [DATA_W-1:0] out_d1_q;
	logic [DATA_W-1:0] out_d2_q;
	logic              out_last_q;
	logic              out_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (msg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_stat_q <= kind_status(cmd.out_kind);
			out_d1_q   <= (cmd.out_kind == KIND_SPP) ? qt_q[DATA_W-1:0] : '0;
			out_d2_q   <= (cmd.out_kind == KIND_SPP) ? qt_q[2*DATA_W-1:DATA_W] : '0;
			out_last_q <= cmd.out_last;
			out_drop_q <= (cmd.out_kind == KIND_CLK) ? drop_q : 1'b0;
		end
	end

	assign msg.valid          = out_valid_q;
	assign msg.status_byte    = out_stat_q;
	assign msg.data_one       = out_d1_q;
	assign msg.data_two       = out_d2_q;
	assign msg.last_of_run    = out_last_q;
	assign msg.clocks_dropped = out_drop_q;

endmodule

// ----- src/mctg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock/transport controller
// Sequences command decode, divisions, state update and word emission.
// ----------------------------------------------------------------------------
module mctg_ctrl #(
	parameter int MAX_CLOCKS = mctg_pkg::MAX_CLOCKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mctg_pkg::dp_status_t              status,
	input  logic [$clog2(MAX_CLOCKS+1)-1:0]   due_cnt,
	output mctg_pkg::ctrl_cmd_t               cmd
);
	import mctg_pkg::*;

	localparam int CNT_W = $clog2(MAX_CLOCKS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_DIVT   = 3'd2;
	localparam logic [2:0] S_DIVL   = 3'd3;
	localparam logic [2:0] S_CALC   = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]       state_q, state_d;
	kind_t            kind_q, kind_d;
	logic [CNT_W-1:0] rem_q, rem_d;

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		rem_d    = rem_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (status.op)
					OP_START, OP_STOP: begin
						cmd.last_neg = 1'b1;
						if (status.on) begin
							kind_d  = (status.op == OP_START) ? KIND_START : KIND_STOP;
							rem_d   = CNT_W'(1);
							state_d = S_EMIT;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_INIT: begin
						if (status.mode_spp && !status.tick_zero) begin
							cmd.div_start = 1'b1;
							cmd.div_src   = DSRC_P16;
							state_d       = S_DIVT;
						end else if (status.mode_align || status.tick_zero) begin
							cmd.div_start = 1'b1;
							cmd.div_src   = DSRC_SPAN;
							state_d       = S_DIVT;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_ADV: begin
						if (status.on && status.adv_fwd) begin
							cmd.div_start = 1'b1;
							cmd.div_src   = DSRC_PER_TICK;
							state_d       = S_DIVT;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DIVT: begin
				if (status.div_done) begin
					cmd.save_qt = 1'b1;
					if (status.op == OP_ADV) begin
						if (status.last_neg) begin
							state_d = S_CALC;
						end else begin
							cmd.div_start = 1'b1;
							cmd.div_src   = DSRC_PER_LAST;
							state_d       = S_DIVL;
						end
					end else begin
						cmd.last_round = 1'b1;
						if (status.mode_spp && !status.tick_zero) begin
							kind_d  = KIND_CONT;
							rem_d   = CNT_W'(2);
							state_d = S_EMIT;
						end else if (status.on) begin
							kind_d  = KIND_START;
							rem_d   = CNT_W'(1);
							state_d = S_EMIT;
						end else begin
							state_d = S_IDLE;
						end
					end
				end
			end
			S_DIVL: begin
				if (status.div_done) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc      = 1'b1;
				cmd.last_tick = 1'b1;
				if (due_cnt == '0) begin
					state_d = S_IDLE;
				end else begin
					kind_d  = KIND_CLK;
					rem_d   = due_cnt;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = kind_q;
					cmd.out_last = rem_q == CNT_W'(1);
					rem_d        = rem_q - 1'b1;
					if (kind_q == KIND_CONT) begin
						kind_d = KIND_SPP;
					end
					if (rem_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_START;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			rem_q   <= rem_d;
		end
	end

endmodule

// ----- src/mctg_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock/transport port checker
// Port-level properties of the emitted word stream, bound to the top level.
// ----------------------------------------------------------------------------
module mctg_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          msg_valid,
	input logic                          msg_ready,
	input logic [mctg_pkg::STAT_W-1:0]   status_byte,
	input logic [mctg_pkg::DATA_W-1:0]   data_one,
	input logic [mctg_pkg::DATA_W-1:0]   data_two,
	input logic                          last_of_run,
	input logic                          clocks_dropped
);
	import mctg_pkg::*;

	// Only the five transport and clock status bytes are ever sent.
	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> (status_byte == ST_START || status_byte == ST_STOP ||
			status_byte == ST_CONT || status_byte == ST_SPP || status_byte == ST_CLOCK))
		else $error("unknown status byte");

	// Data bytes are only populated on song position words.
	a_data_spp_only: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && status_byte != ST_SPP) |-> (data_one == '0 && data_two == '0))
		else $error("data bytes on a non song position word");

	// Continue is always followed by its song position, so it never ends a run.
	a_cont_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && status_byte == ST_CONT) |-> !last_of_run)
		else $error("continue ended a run");

	// The overflow flag is only set on timing clocks.
	a_drop_on_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && clocks_dropped) |-> status_byte == ST_CLOCK)
		else $error("drop flag on a non clock word");

	// A stalled word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_ready) |=> (msg_valid && $stable(status_byte) &&
			$stable(last_of_run)))
		else $error("stalled word changed");

endmodule

bind midi_clock_transport_generator_top mctg_chk u_mctg_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.msg_valid      (msg.valid),
	.msg_ready      (msg.ready),
	.status_byte    (msg.status_byte),
	.data_one       (msg.data_one),
	.data_two       (msg.data_two),
	.last_of_run    (msg.last_of_run),
	.clocks_dropped (msg.clocks_dropped)
);
